// ----- hdl/tlt_pkg.sv -----
// Shared types and constants for the tone lane tracker.
package tlt_pkg;
  localparam int MaxLanes   = 16;
  localparam int PeakDepth  = 2 * MaxLanes;
  localparam int LaneIdxW   = $clog2(MaxLanes);
  localparam int LaneCntW   = $clog2(MaxLanes + 1);
  localparam int PeakIdxW   = $clog2(PeakDepth);
  localparam int PeakCntW   = $clog2(PeakDepth + 1);
  localparam int PeakEntryW = 36;

  localparam logic [16:0] AlphaYoung  = 17'd29491;
  localparam logic [16:0] AlphaOld    = 17'd13107;
  localparam logic [16:0] ConfGain    = 17'd11796;
  localparam logic [16:0] ConfOne     = 17'd65536;
  localparam logic [16:0] ConfDecay   = 17'd56361;
  localparam logic [16:0] ConfFloor   = 17'd1966;
  localparam logic [16:0] ConfNewLow  = 17'd6554;
  localparam logic [16:0] ConfNewHigh = 17'd42598;
  localparam logic [16:0] RecipThird  = 17'd87382;
  localparam logic [17:0] DiffClamp   = 18'd1997;

  localparam logic [3:0] AddrRadius  = 4'd0;
  localparam logic [3:0] AddrRelease = 4'd4;
  localparam logic [3:0] AddrMinSnr  = 4'd8;

  typedef struct packed {
    logic [15:0]        id;
    logic [17:0]        freq;
    logic signed [16:0] snr;
    logic [16:0]        conf;
    logic [7:0]         age;
    logic [10:0]        missed;
  } lane_t;

  typedef struct packed {
    logic [15:0]        id;
    logic [17:0]        freq;
    logic signed [16:0] snr;
    logic [16:0]        conf;
    logic [31:0]        frame;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [10:0] radius;
    logic [9:0]  release_frames;
    logic [12:0] min_snr;
  } cfg_t;
endpackage

// ----- hdl/tone_lane_tracker_top.sv -----
// Tone lane tracker top level: stream ports, register port and output register.
// A peak beat steps through accept, search (one lane per search cycle), decide, multiply,
// write back and finish, and skips multiply and write back when no lane matches; an
// end-of-frame beat adds decay and compaction over the lanes and opening over the peaks,
// all through one shared multiplier. One beat is worked at a time; output stalls can hold it.
// Reset clears the lane store, counters and output valid, and sets the configuration registers to their defaults.
module tone_lane_tracker_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // peak_frequency[17:0], peak_snr[34:18], zero fill
  input  logic         s_axis_tuser,   // peak_valid
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // lane_id, lane_frequency, lane_snr, lane_confidence,
                                       // frame_index, zero fill
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import tlt_pkg::*;

  cfg_t    cfg_q;
  logic    ov_q;
  result_t out_q;
  logic    res_valid, res_ready;
  result_t res;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius         <= 11'd320;
      cfg_q.release_frames <= 10'd24;
      cfg_q.min_snr        <= 13'd1536;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        AddrRadius:  cfg_q.radius         <= pwdata[10:0];
        AddrRelease: cfg_q.release_frames <= pwdata[9:0];
        AddrMinSnr:  cfg_q.min_snr        <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr)
      AddrRadius:  prdata = {21'b0, cfg_q.radius};
      AddrRelease: prdata = {22'b0, cfg_q.release_frames};
      AddrMinSnr:  prdata = {19'b0, cfg_q.min_snr};
      default:     prdata = '0;
    endcase
  end

  tlt_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_peak_i  (s_axis_tuser),
    .in_freq_i  (s_axis_tdata[17:0]),
    .in_snr_i   ($signed(s_axis_tdata[34:18])),
    .in_last_i  (s_axis_tlast),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !ov_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (res_ready) begin
      ov_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {4'b0, out_q.frame, out_q.conf, out_q.snr, out_q.freq, out_q.id};
endmodule

// ----- hdl/tlt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tlt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- hdl/tlt_mul.sv -----
// Shared signed multiplier with registered product.
module tlt_mul (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [18:0] a_i,
  input  logic [16:0]        b_i,
  output logic signed [36:0] prod_o
);
  logic signed [36:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 37'(a_i * $signed({1'b0, b_i}));
    end
  end

  assign prod_o = prod_q;
endmodule

// ----- hdl/tlt_core.sv -----
// Lane store and sequencer: association, decay, compaction and lane opening.
module tlt_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlt_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_peak_i,
  input  logic [17:0]         in_freq_i,
  input  logic signed [16:0]  in_snr_i,
  input  logic                in_last_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output tlt_pkg::result_t    res_o
);
  import tlt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_UPD_MUL, S_UPD_WR, S_DEC_MUL, S_DEC_WR, S_COMPACT,
    S_NEW_RD, S_NEW_CHK, S_NEW_WR, S_END, S_FINISH
  } state_e;

  state_e                state_q;
  lane_t                 lane_q [MaxLanes];
  logic [MaxLanes-1:0]   claimed_q;
  logic [LaneCntW-1:0]   count_q, idx_q, kept_q;
  logic [LaneIdxW-1:0]   best_q;
  logic                  found_q;
  logic [17:0]           bestd_q;
  logic [PeakCntW-1:0]   pc_q, p_q;
  logic [15:0]           next_id_q;
  logic [31:0]           frame_q;
  logic                  peak_q, last_q;
  logic [17:0]           pf_q;
  logic signed [16:0]    ps_q;
  logic                  pend_v_q;
  result_t               pend_q;

  logic [LaneIdxW-1:0]   ridx;
  lane_t                 rd;
  logic [17:0]           lane_dist;
  logic                  mul_en;
  logic signed [18:0]    mul_a;
  logic [16:0]           mul_b;
  logic signed [36:0]    prod;
  logic                  ram_we, ram_re;
  logic [PeakIdxW-1:0]   ram_waddr;
  logic [PeakEntryW-1:0] ram_wdata, ram_rdata;
  logic [17:0]           pk_freq;
  logic signed [16:0]    pk_snr;
  logic                  pk_claimed;
  logic signed [17:0]    diff;
  logic signed [18:0]    ds;
  logic signed [36:0]    fstep;
  lane_t                 upd, fresh;
  logic [17:0]           conf_sum;
  logic [16:0]           new_conf, q_conf;
  logic [9:0]            rf;
  logic                  stall, keep;

  assign ridx   = (state_q == S_UPD_MUL || state_q == S_UPD_WR) ? best_q : idx_q[LaneIdxW-1:0];
  assign rd     = lane_q[ridx];
  assign lane_dist = (pf_q > rd.freq) ? pf_q - rd.freq : rd.freq - pf_q;
  assign pk_freq    = ram_rdata[17:0];
  assign pk_snr     = $signed(ram_rdata[34:18]);
  assign pk_claimed = ram_rdata[35];
  assign diff   = 18'($signed({pk_snr[16], pk_snr}) - $signed({5'b0, cfg_i.min_snr}));
  assign rf     = (cfg_i.release_frames < 10'd2) ? 10'd2 : cfg_i.release_frames;
  assign keep   = !(rd.missed > {1'b0, rf} || rd.conf < ConfFloor);

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      S_UPD_MUL: begin
        mul_en = 1'b1;
        mul_a  = 19'($signed({1'b0, pf_q}) - $signed({1'b0, rd.freq}));
        mul_b  = (rd.age < 8'd4) ? AlphaYoung : AlphaOld;
      end
      S_DEC_MUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({2'b0, rd.conf});
        mul_b  = ConfDecay;
      end
      S_NEW_CHK: begin
        mul_en = 1'b1;
        mul_a  = 19'(diff);
        mul_b  = RecipThird;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  tlt_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  tlt_ram #(.Width(PeakEntryW), .Depth(PeakDepth)) u_peaks (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(p_q[PeakIdxW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign ram_waddr = pc_q[PeakIdxW-1:0];
  assign ram_we    = (state_q == S_UPD_WR && !stall) ||
                     (state_q == S_SEARCH && idx_q >= count_q && !found_q);
  assign ram_wdata = {(state_q == S_UPD_WR), ps_q, pf_q};
  assign ram_re    = (state_q == S_NEW_RD);

  always_comb begin
    fstep      = (prod + 37'sd32768) >>> 16;
    ds         = 19'($signed({{2{ps_q[16]}}, ps_q}) - $signed({{2{rd.snr[16]}}, rd.snr}) + 19'sd2);
    conf_sum   = {1'b0, rd.conf} + {1'b0, ConfGain};
    upd        = rd;
    upd.freq   = 18'($signed({1'b0, rd.freq}) + fstep);
    upd.snr    = 17'($signed({{2{rd.snr[16]}}, rd.snr}) + (ds >>> 2));
    upd.conf   = (conf_sum > {1'b0, ConfOne}) ? ConfOne : conf_sum[16:0];
    upd.age    = (rd.age == 8'd255) ? rd.age : rd.age + 8'd1;
    upd.missed = '0;
    q_conf     = 17'(prod >>> 12);
    if (diff <= 18'sd0) begin
      new_conf = ConfNewLow;
    end else if (diff >= $signed(DiffClamp)) begin
      new_conf = ConfNewHigh;
    end else if (q_conf < ConfNewLow) begin
      new_conf = ConfNewLow;
    end else begin
      new_conf = q_conf;
    end
    fresh.id     = next_id_q;
    fresh.freq   = pk_freq;
    fresh.snr    = pk_snr;
    fresh.conf   = new_conf;
    fresh.age    = 8'd1;
    fresh.missed = '0;
  end

  assign stall       = pend_v_q && !res_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = pend_v_q &&
                       (state_q == S_UPD_WR || state_q == S_NEW_WR || state_q == S_FINISH);
  always_comb begin
    res_o      = pend_q;
    res_o.last = (state_q == S_FINISH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      for (int i = 0; i < MaxLanes; i++) begin
        lane_q[i] <= '0;
      end
      claimed_q <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      kept_q    <= '0;
      best_q    <= '0;
      found_q   <= 1'b0;
      bestd_q   <= '0;
      pc_q      <= '0;
      p_q       <= '0;
      next_id_q <= '0;
      frame_q   <= '0;
      peak_q    <= 1'b0;
      last_q    <= 1'b0;
      pf_q      <= '0;
      ps_q      <= '0;
      pend_v_q  <= 1'b0;
      pend_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            peak_q  <= in_peak_i;
            last_q  <= in_last_i;
            pf_q    <= in_freq_i;
            ps_q    <= in_snr_i;
            idx_q   <= '0;
            found_q <= 1'b0;
            bestd_q <= {7'b0, cfg_i.radius};
            if (in_peak_i && pc_q < PeakCntW'(PeakDepth)) begin
              state_q <= S_SEARCH;
            end else if (in_last_i) begin
              state_q <= S_DEC_MUL;
            end
          end
        end
        S_SEARCH: begin
          if (idx_q < count_q) begin
            if (!claimed_q[ridx] && lane_dist < bestd_q) begin
              bestd_q <= lane_dist;
              best_q  <= ridx;
              found_q <= 1'b1;
            end
            idx_q <= idx_q + 1'b1;
          end else if (found_q) begin
            state_q <= S_UPD_MUL;
          end else begin
            pc_q    <= pc_q + 1'b1;
            idx_q   <= '0;
            state_q <= last_q ? S_DEC_MUL : S_FINISH;
          end
        end
        S_UPD_MUL: begin
          state_q <= S_UPD_WR;
        end
        S_UPD_WR: begin
          if (!stall) begin
            lane_q[best_q]    <= upd;
            claimed_q[best_q] <= 1'b1;
            pc_q              <= pc_q + 1'b1;
            pend_v_q          <= 1'b1;
            pend_q            <= {upd.id, upd.freq, upd.snr, upd.conf, frame_q, 1'b0};
            idx_q             <= '0;
            state_q           <= last_q ? S_DEC_MUL : S_FINISH;
          end
        end
        S_DEC_MUL: begin
          if (idx_q < count_q) begin
            if (claimed_q[ridx]) begin
              idx_q <= idx_q + 1'b1;
            end else begin
              state_q <= S_DEC_WR;
            end
          end else begin
            idx_q   <= '0;
            kept_q  <= '0;
            state_q <= S_COMPACT;
          end
        end
        S_DEC_WR: begin
          lane_q[ridx].conf   <= 17'(prod >>> 16);
          lane_q[ridx].missed <= (rd.missed == 11'd2047) ? rd.missed : rd.missed + 11'd1;
          idx_q               <= idx_q + 1'b1;
          state_q             <= S_DEC_MUL;
        end
        S_COMPACT: begin
          if (idx_q < count_q) begin
            if (keep) begin
              lane_q[kept_q[LaneIdxW-1:0]] <= rd;
              kept_q                       <= kept_q + 1'b1;
            end
            idx_q <= idx_q + 1'b1;
          end else begin
            count_q <= kept_q;
            p_q     <= '0;
            state_q <= S_NEW_RD;
          end
        end
        S_NEW_RD: begin
          if (p_q < pc_q && count_q < LaneCntW'(MaxLanes)) begin
            state_q <= S_NEW_CHK;
          end else begin
            state_q <= S_END;
          end
        end
        S_NEW_CHK: begin
          if (pk_claimed) begin
            p_q     <= p_q + 1'b1;
            state_q <= S_NEW_RD;
          end else begin
            state_q <= S_NEW_WR;
          end
        end
        S_NEW_WR: begin
          if (!stall) begin
            lane_q[count_q[LaneIdxW-1:0]] <= fresh;
            count_q   <= count_q + 1'b1;
            next_id_q <= next_id_q + 16'd1;
            p_q       <= p_q + 1'b1;
            pend_v_q  <= 1'b1;
            pend_q    <= {fresh.id, fresh.freq, fresh.snr, fresh.conf, frame_q, 1'b0};
            state_q   <= S_NEW_RD;
          end
        end
        S_END: begin
          claimed_q <= '0;
          pc_q      <= '0;
          if (frame_q != 32'hFFFF_FFFF) begin
            frame_q <= frame_q + 32'd1;
          end
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (!stall) begin
            pend_v_q <= 1'b0;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ----- tb/tone_lane_checker.sv -----
// Lane tracker checker: watches both streams, predicts lane reports and compares them.
module tone_lane_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [39:0]  s_data_i,
  input  logic         s_user_i,
  input  logic         s_last_i,
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  input  logic [103:0] m_data_i,
  input  logic         m_last_i,
  input  logic [10:0]  radius_i,
  input  logic [9:0]   release_i,
  input  logic [12:0]  min_snr_i,
  output int           fail_count_o,
  output int           pending_o,
  output int           report_count_o
);
  import tlt_pkg::*;

  lane_t           lanes [MaxLanes];
  logic            lane_hit [MaxLanes];
  int              lane_cnt;
  logic [17:0]     pk_freq [PeakDepth];
  logic signed [16:0] pk_snr [PeakDepth];
  logic            pk_hit [PeakDepth];
  int              pk_cnt;
  logic [15:0]     next_id;
  logic [31:0]     frame_cnt;
  result_t         lane_reports [$];

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b != 0) && ((a < 0) != (b < 0))) q = q - 1;
    return q;
  endfunction

  task automatic queue_report(int l);
    result_t r;
    r.id    = lanes[l].id;
    r.freq  = lanes[l].freq;
    r.snr   = lanes[l].snr;
    r.conf  = lanes[l].conf;
    r.frame = frame_cnt;
    r.last  = 1'b0;
    lane_reports.insert(lane_reports.size(), r);
  endtask

  task automatic claim_peak(logic [17:0] pf, logic signed [16:0] ps);
    int best;
    longint bestd;
    longint d;
    longint a;
    if (pk_cnt >= PeakDepth) return;
    pk_freq[pk_cnt] = pf;
    pk_snr[pk_cnt] = ps;
    pk_hit[pk_cnt] = 1'b0;
    best = -1;
    bestd = radius_i;
    for (int l = 0; l < lane_cnt; l++) begin
      if (lane_hit[l]) continue;
      d = longint'(pf) - longint'(lanes[l].freq);
      if (d < 0) d = -d;
      if (d < bestd) begin
        bestd = d;
        best = l;
      end
    end
    if (best >= 0) begin
      a = (lanes[best].age < 4) ? 29491 : 13107;
      lanes[best].freq = 18'(longint'(lanes[best].freq) + floor_div(
          (longint'(pf) - longint'(lanes[best].freq)) * a + 32768, 65536));
      lanes[best].snr = 17'(longint'(lanes[best].snr) +
          floor_div(longint'(ps) - longint'(lanes[best].snr) + 2, 4));
      lanes[best].conf = (lanes[best].conf + 11796 > 65536) ? 17'd65536
                                                             : lanes[best].conf + 17'd11796;
      if (lanes[best].age < 255) lanes[best].age = lanes[best].age + 1;
      lanes[best].missed = '0;
      lane_hit[best] = 1'b1;
      pk_hit[pk_cnt] = 1'b1;
      queue_report(best);
    end
    pk_cnt++;
  endtask

  task automatic close_frame();
    int kept;
    longint rf;
    longint diff;
    longint c;
    rf = (release_i < 2) ? 2 : release_i;
    for (int l = 0; l < lane_cnt; l++) begin
      if (lane_hit[l]) continue;
      if (lanes[l].missed < 2047) lanes[l].missed = lanes[l].missed + 1;
      lanes[l].conf = 17'((longint'(lanes[l].conf) * 56361) >>> 16);
    end
    kept = 0;
    for (int l = 0; l < lane_cnt; l++) begin
      if (lanes[l].missed > rf || lanes[l].conf < 1966) continue;
      lanes[kept] = lanes[l];
      kept++;
    end
    lane_cnt = kept;
    for (int p = 0; p < pk_cnt && lane_cnt < MaxLanes; p++) begin
      if (pk_hit[p]) continue;
      lanes[lane_cnt].id = next_id;
      next_id = next_id + 1;
      lanes[lane_cnt].freq = pk_freq[p];
      lanes[lane_cnt].snr = pk_snr[p];
      diff = longint'(pk_snr[p]) - longint'(min_snr_i);
      if (diff <= 0) c = 6554;
      else begin
        c = diff * 64 / 3;
        if (c < 6554) c = 6554;
        if (c > 42598) c = 42598;
      end
      lanes[lane_cnt].conf = 17'(c);
      lanes[lane_cnt].age = 8'd1;
      lanes[lane_cnt].missed = '0;
      queue_report(lane_cnt);
      lane_cnt++;
    end
    for (int l = 0; l < MaxLanes; l++) lane_hit[l] = 1'b0;
    pk_cnt = 0;
    if (frame_cnt != 32'hFFFF_FFFF) frame_cnt = frame_cnt + 1;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int before_cnt;
    result_t want;
    result_t got;
    if (!rst_ni) begin
      lane_cnt = 0;
      pk_cnt = 0;
      next_id = '0;
      frame_cnt = '0;
      for (int l = 0; l < MaxLanes; l++) begin
        lanes[l] = '0;
        lane_hit[l] = 1'b0;
      end
      lane_reports.delete();
      fail_count_o = 0;
      report_count_o = 0;
      pending_o = 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        got.id = m_data_i[15:0];
        got.freq = m_data_i[33:16];
        got.snr = m_data_i[50:34];
        got.conf = m_data_i[67:51];
        got.frame = m_data_i[99:68];
        got.last = m_last_i;
        report_count_o++;
        if (lane_reports.size() == 0) report_mismatch("unexpected beat", 1, 0);
        else begin
          want = lane_reports.pop_front();
          if (got.id != want.id) report_mismatch("lane_id", got.id, want.id);
          if (got.freq != want.freq) report_mismatch("lane_frequency", got.freq, want.freq);
          if (got.snr != want.snr) report_mismatch("lane_snr", got.snr, want.snr);
          if (got.conf != want.conf) report_mismatch("lane_confidence", got.conf, want.conf);
          if (got.frame != want.frame) report_mismatch("frame_index", got.frame, want.frame);
          if (got.last != want.last) report_mismatch("last_of_run", got.last, want.last);
          if (m_data_i[103:100] != '0) report_mismatch("zero fill", m_data_i[103:100], 0);
        end
      end
      if (s_valid_i && s_ready_i) begin
        before_cnt = lane_reports.size();
        if (s_user_i) claim_peak(s_data_i[17:0], s_data_i[34:18]);
        if (s_last_i) close_frame();
        if (lane_reports.size() > before_cnt) lane_reports[$].last = 1'b1;
      end
      pending_o = lane_reports.size();
    end
  end
endmodule

// ----- tb/tb_tone_lane_tracker_top.sv -----
// Lane tracker testbench top: clock, reset, register writes, peak stimulus and verdict.
module tb_tone_lane_tracker_top;
  import tlt_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  logic [10:0]  radius_q;
  logic [9:0]   release_q;
  logic [12:0]  min_snr_q;
  int           fail_count;
  int           pending;
  int           report_count;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           hold_cycles = 0;
  logic         hold_go = 1'b0;
  logic         hold_seen = 1'b0;
  int           peaks_sent;
  int           frames_sent;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tone_lane_tracker_top dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  tone_lane_checker u_checker (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .s_user_i(s_axis_tuser), .s_last_i(s_axis_tlast),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .m_last_i(m_axis_tlast),
    .radius_i(radius_q), .release_i(release_q), .min_snr_i(min_snr_q),
    .fail_count_o(fail_count), .pending_o(pending), .report_count_o(report_count)
  );

  // track the register file as written
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 11'd320;
      release_q <= 10'd24;
      min_snr_q <= 13'd1536;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr)
        AddrRadius:  radius_q <= pwdata[10:0];
        AddrRelease: release_q <= pwdata[9:0];
        AddrMinSnr:  min_snr_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cycles <= 3000;
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic [3:0] addr, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_peak(logic vld, logic [17:0] freq, logic signed [16:0] snr,
                           logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, snr, freq};
    s_axis_tuser <= vld;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (vld) peaks_sent++;
    if (last) frames_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic logic signed [16:0] rand_snr();
    return 17'(int'($urandom_range(76800)) - 25600);
  endfunction

  // well-formed frame: peaks spread from a base frequency, a few strays, then end
  task automatic send_frame(int n, int base, int spread);
    int f;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) f = $urandom_range(196607);
      else f = base + i * spread + int'($urandom_range(200)) - 100;
      if (f < 0) f = 0;
      if (f > 196607) f = 196607;
      send_peak(1'b1, 18'(f), rand_snr(), (i == n - 1) && ($urandom_range(3) != 0));
    end
    if (s_axis_tlast == 1'b0 || n == 0) send_peak(1'b0, 18'($urandom), rand_snr(), 1'b1);
  endtask

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    peaks_sent = 0;
    frames_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(posedge clk_i);

    // directed: extremes, empty markers, too many peaks, full store, saturation
    send_peak(1'b0, 18'h3FFFF, 17'h1FFFF, 1'b0);
    send_peak(1'b1, 18'd0, -17'sd25600, 1'b0);
    send_peak(1'b1, 18'd196607, 17'sd51200, 1'b0);
    send_peak(1'b1, 18'h3FFFF, 17'sd0, 1'b0);
    send_peak(1'b1, 18'd1000, 17'sd1536, 1'b1);
    send_peak(1'b1, 18'd1010, -17'sd65536, 1'b1);
    send_peak(1'b1, 18'd196600, 17'sd65535, 1'b1);
    send_peak(1'b0, 18'd0, 17'sd0, 1'b1);
    for (int i = 0; i < 36; i++)
      send_peak(1'b1, 18'(i * 5000), 17'(i * 700), i == 35);
    settle();

    write_reg(AddrRadius, 32'd64);
    write_reg(AddrRelease, 32'd0);
    write_reg(AddrMinSnr, 32'd7680);
    repeat (6) send_peak(1'b0, 18'd0, 17'sd0, 1'b1);
    settle();
    write_reg(AddrRadius, 32'h7FF);
    write_reg(AddrRelease, 32'h3FF);
    write_reg(AddrMinSnr, 32'd0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      if (ph == 2) hold_go = 1'b1;
      for (int fr = 0; fr < 8; fr++)
        send_frame($urandom_range(8), $urandom_range(150000), $urandom_range(4000));
      if (ph == 2) begin
        for (int i = 0; i < 20; i++)
          send_peak(1'b1, 18'($urandom_range(196607)), rand_snr(), 1'b0);
        send_peak(1'b0, 18'd0, 17'sd0, 1'b1);
      end
      settle();
      write_reg(AddrRadius, 32'($urandom_range(1280, 64)));
      write_reg(AddrRelease, 32'($urandom_range(1023, 2)));
      write_reg(AddrMinSnr, 32'($urandom_range(7680)));
      if (ph == 5) write_reg(AddrRadius, 32'd1280);
      if (ph == 6) write_reg(AddrRelease, 32'd2);
    end

    settle();
    $display("covered %0d peaks over %0d frames, %0d lane reports checked",
             peaks_sent, frames_sent, report_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hdl/tlt_pkg.sv
hdl/tlt_ram.sv
hdl/tlt_mul.sv
hdl/tlt_core.sv
hdl/tone_lane_tracker_top.sv
tb/tone_lane_checker.sv
tb/tb_tone_lane_tracker_top.sv
